FILE: sv/rarst_pkg.sv
// ----------------------------------------------------------------------------
// rarst_pkg
// Shared types and field widths for the range-add / range-sum tree block.
// ----------------------------------------------------------------------------
package rarst_pkg;

    localparam int unsigned LOW_W    = 10;
    localparam int unsigned HIGH_W   = 10;
    localparam int unsigned AMOUNT_W = 32;
    localparam int unsigned TOTAL_W  = 64;
    localparam int unsigned LEN_CFG_W = 11;
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 64;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic pend_we;
        logic below_we;
    } rarst_wr_t;

endpackage

FILE: sv/rarst_store.sv
// ----------------------------------------------------------------------------
// rarst_store
// Node store: pending add and sum-below words, one shared address, registered read.
// ----------------------------------------------------------------------------
module rarst_store
    import rarst_pkg::*;
#(
    parameter int unsigned AW = 11
) (
    input  logic                 aclk,
    input  logic [AW-1:0]        addr,
    input  rarst_wr_t            wr,
    input  logic [TOTAL_W-1:0]   pend_wdata,
    input  logic [TOTAL_W-1:0]   below_wdata,
    output logic [TOTAL_W-1:0]   pend_rdata,
    output logic [TOTAL_W-1:0]   below_rdata
);

    localparam int unsigned SLOTS = 2 ** AW;

    logic [TOTAL_W-1:0] pend_mem  [SLOTS];
    logic [TOTAL_W-1:0] below_mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr.pend_we) begin
            pend_mem[addr] <= pend_wdata;
        end
        pend_rdata <= pend_mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (wr.below_we) begin
            below_mem[addr] <= below_wdata;
        end
        below_rdata <= below_mem[addr];
    end

endmodule

FILE: sv/range_add_range_sum_tree.sv
// ----------------------------------------------------------------------------
// range_add_range_sum_tree
// Lazy segment tree over a signed 64-bit array with range add and range sum.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser is the request kind (add or sum
// query), s_tdata carries the range and the add amount. Each request gives
// one transfer on the m_ stream: m_tdata is the wrapped 64-bit sum (zero for
// an add), m_tuser is set when the range was invalid and nothing changed.
// The block works on one request at a time. A sequencer walks the tree with a
// small node stack and one multiplier over the node store. The root needs no
// pop; every other node is first popped from the stack. A request visits up to
// about four nodes per tree level; an add over the whole array touches only the
// root, and an invalid range skips the tree walk.
// After reset, and after every write of active_length, a clearing pass zeroes
// the node store; s_tready stays low meanwhile.
// The result sits in an output register; while the receiver stalls, the block
// may work one more request, then holds its finished result and does not
// start the next one.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree
    import rarst_pkg::*;
#(
    parameter int unsigned ARRAY_DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // range_low [9:0], range_high [19:10], add_amount [51:20], zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // range_total [63:0]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status
    output logic                  m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int unsigned AW    = $clog2(2 * ARRAY_DEPTH);
    localparam int unsigned IW    = $clog2(ARRAY_DEPTH);
    localparam int unsigned LW    = $clog2(ARRAY_DEPTH + 1);
    localparam int unsigned SPANW = IW + 1;
    localparam int unsigned CW    = (LW > LOW_W) ? LW : LOW_W;
    localparam int unsigned SD    = 2 * (IW + 2);
    localparam int unsigned SIW   = $clog2(SD);
    localparam int unsigned SPW   = $clog2(SD + 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_POP   = 4'd2;
    localparam logic [3:0] S_EVAL  = 4'd3;
    localparam logic [3:0] S_WB    = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_PLR   = 4'd6;
    localparam logic [3:0] S_PLW   = 4'd7;
    localparam logic [3:0] S_PRR   = 4'd8;
    localparam logic [3:0] S_PRW   = 4'd9;
    localparam logic [3:0] S_DESC  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    localparam logic REG_LENGTH = 1'b0;

    logic [3:0]          state_reg, state_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [SPW-1:0]      sp_reg, sp_next;
    logic                kind_reg, kind_next;
    logic [AMOUNT_W-1:0] amt_reg, amt_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                status_reg, status_next;
    logic [TOTAL_W-1:0]  p_reg, p_next;
    logic [TOTAL_W-1:0]  bs_reg, bs_next;
    logic [TOTAL_W-1:0]  prod_reg, prod_next;
    logic [AW-1:0]       n_reg, n_next;
    logic [IW-1:0]       a_reg, a_next, b_reg, b_next, lo_reg, lo_next, hi_reg, hi_next;
    logic                m_valid_reg, m_valid_next;
    logic [TOTAL_W-1:0]  m_data_reg, m_data_next;
    logic                m_user_reg, m_user_next;

    logic [AW-1:0] stk_n_reg  [SD];
    logic [IW-1:0] stk_a_reg  [SD];
    logic [IW-1:0] stk_b_reg  [SD];
    logic [IW-1:0] stk_lo_reg [SD];
    logic [IW-1:0] stk_hi_reg [SD];

    logic          push0, push1;
    logic [AW-1:0] push0_n, push1_n;
    logic [IW-1:0] push0_a, push0_b, push0_lo, push0_hi;
    logic [IW-1:0] push1_a, push1_b, push1_lo, push1_hi;
    logic [SPW-1:0] sp_m1, sp_p1;

    logic [AW-1:0]       addr;
    rarst_wr_t           wr;
    logic [TOTAL_W-1:0]  pend_wd, below_wd, rd_pend, rd_below;

    logic [IW-1:0]       mid;
    logic                full;
    logic [AW-1:0]       left_n, right_n, half_n;
    logic [SPANW-1:0]    span, cnt, mul_b;
    logic [TOTAL_W-1:0]  v64, mul_a;
    logic                cfg_wr, s_acc;
    logic [31:0]         cfg_v;
    logic [CW-1:0]       lo_w, hi_w, len_w;
    logic                bad_range;
    logic [AW-1:0]       after_pop_state_dummy;

    assign pready   = 1'b1;
    assign prdata   = 32'(len_reg);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LENGTH);
    assign cfg_v  = {21'd0, pwdata[LEN_CFG_W-1:0]};
    assign s_acc  = s_tvalid && s_tready;

    assign lo_w      = CW'(s_tdata[LOW_W-1:0]);
    assign hi_w      = CW'(s_tdata[LOW_W+HIGH_W-1:LOW_W]);
    assign len_w     = CW'(len_reg);
    assign bad_range = (lo_w > hi_w) || (hi_w >= len_w);

    assign mid     = a_reg + ((b_reg - a_reg) >> 1);
    assign full    = (lo_reg == a_reg) && (hi_reg == b_reg);
    assign left_n  = n_reg + AW'(1);
    assign half_n  = AW'(mid - a_reg) + AW'(1);
    assign right_n = n_reg + (half_n << 1);
    assign span    = SPANW'(b_reg) - SPANW'(a_reg) + SPANW'(1);
    assign cnt     = SPANW'(hi_reg) - SPANW'(lo_reg) + SPANW'(1);
    assign v64     = {{(TOTAL_W-AMOUNT_W){amt_reg[AMOUNT_W-1]}}, amt_reg};
    assign mul_a   = (kind_reg == REQ_QUERY) ? rd_pend : v64;
    assign mul_b   = (kind_reg == REQ_QUERY) ? span : cnt;
    assign sp_m1   = sp_reg - SPW'(1);
    assign sp_p1   = sp_reg + SPW'(1);
    assign after_pop_state_dummy = stk_n_reg[sp_m1[SIW-1:0]];

    always_comb begin
        unique case (state_reg)
            S_CLEAR:        addr = clr_reg;
            S_IDLE:         addr = '0;
            S_POP:          addr = after_pop_state_dummy;
            S_PLR, S_PLW:   addr = left_n;
            S_PRR, S_PRW:   addr = right_n;
            default:        addr = n_reg;
        endcase
    end

    always_comb begin
        wr       = '0;
        pend_wd  = '0;
        below_wd = bs_reg + prod_reg;
        unique case (state_reg)
            S_CLEAR: begin
                wr.pend_we  = 1'b1;
                wr.below_we = 1'b1;
                below_wd    = '0;
            end
            S_EVAL: begin
                if (kind_reg == REQ_ADD && full) begin
                    wr.pend_we = 1'b1;
                    pend_wd    = rd_pend + v64;
                end
            end
            S_WB: begin
                wr.below_we = 1'b1;
                wr.pend_we  = (kind_reg == REQ_QUERY);
            end
            S_PLW, S_PRW: begin
                wr.pend_we = 1'b1;
                pend_wd    = rd_pend + p_reg;
            end
            default: begin
            end
        endcase
    end

    rarst_store #(
        .AW(AW)
    ) u_store (
        .aclk        (aclk),
        .addr        (addr),
        .wr          (wr),
        .pend_wdata  (pend_wd),
        .below_wdata (below_wd),
        .pend_rdata  (rd_pend),
        .below_rdata (rd_below)
    );

    always_comb begin
        push0 = 1'b0;
        push1 = 1'b0;
        push0_n = left_n;   push0_a = a_reg;            push0_b = mid;
        push0_lo = lo_reg;  push0_hi = hi_reg;
        push1_n = right_n;  push1_a = mid + IW'(1);     push1_b = b_reg;
        push1_lo = mid + IW'(1);
        push1_hi = hi_reg;
        if (state_reg == S_DESC) begin
            push0 = 1'b1;
            if (lo_reg > mid) begin
                push0_n = right_n;  push0_a = mid + IW'(1);  push0_b = b_reg;
            end else if (hi_reg > mid) begin
                push0_hi = mid;
                push1    = 1'b1;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        clr_next     = clr_reg;
        sp_next      = sp_reg;
        kind_next    = kind_reg;
        amt_next     = amt_reg;
        total_next   = total_reg;
        status_next  = status_reg;
        p_next       = p_reg;
        bs_next      = bs_reg;
        prod_next    = prod_reg;
        n_next       = n_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    kind_next   = s_tuser;
                    amt_next    = s_tdata[LOW_W+HIGH_W+AMOUNT_W-1:LOW_W+HIGH_W];
                    total_next  = '0;
                    status_next = bad_range ? STATUS_INVALID : STATUS_DONE;
                    n_next      = '0;
                    a_next      = '0;
                    b_next      = IW'(len_reg - LW'(1));
                    lo_next     = IW'(lo_w);
                    hi_next     = IW'(hi_w);
                    sp_next     = '0;
                    state_next  = bad_range ? S_FIN : S_EVAL;
                end
            end
            S_POP: begin
                n_next     = stk_n_reg[sp_m1[SIW-1:0]];
                a_next     = stk_a_reg[sp_m1[SIW-1:0]];
                b_next     = stk_b_reg[sp_m1[SIW-1:0]];
                lo_next    = stk_lo_reg[sp_m1[SIW-1:0]];
                hi_next    = stk_hi_reg[sp_m1[SIW-1:0]];
                sp_next    = sp_m1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                p_next    = rd_pend;
                bs_next   = rd_below;
                prod_next = mul_a * TOTAL_W'(mul_b);
                if (kind_reg == REQ_ADD) begin
                    if (full) begin
                        state_next = (sp_reg == '0) ? S_FIN : S_POP;
                    end else begin
                        state_next = S_WB;
                    end
                end else if (full) begin
                    total_next = total_reg + rd_below;
                    state_next = S_ACC;
                end else begin
                    state_next = S_WB;
                end
            end
            S_WB: begin
                state_next = (kind_reg == REQ_QUERY) ? S_PLR : S_DESC;
            end
            S_ACC: begin
                total_next = total_reg + prod_reg;
                state_next = (sp_reg == '0) ? S_FIN : S_POP;
            end
            S_PLR: state_next = S_PLW;
            S_PLW: state_next = S_PRR;
            S_PRR: state_next = S_PRW;
            S_PRW: state_next = S_DESC;
            S_DESC: begin
                sp_next    = push1 ? sp_reg + SPW'(2) : sp_p1;
                state_next = S_POP;
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = total_reg;
                    m_user_next  = status_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_wr) begin
            if (cfg_v == 32'd0) begin
                len_next = LW'(1);
            end else if (cfg_v > 32'(ARRAY_DEPTH)) begin
                len_next = LW'(ARRAY_DEPTH);
            end else begin
                len_next = LW'(cfg_v);
            end
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            stk_n_reg[sp_reg[SIW-1:0]]  <= push0_n;
            stk_a_reg[sp_reg[SIW-1:0]]  <= push0_a;
            stk_b_reg[sp_reg[SIW-1:0]]  <= push0_b;
            stk_lo_reg[sp_reg[SIW-1:0]] <= push0_lo;
            stk_hi_reg[sp_reg[SIW-1:0]] <= push0_hi;
        end
        if (push1) begin
            stk_n_reg[sp_p1[SIW-1:0]]  <= push1_n;
            stk_a_reg[sp_p1[SIW-1:0]]  <= push1_a;
            stk_b_reg[sp_p1[SIW-1:0]]  <= push1_b;
            stk_lo_reg[sp_p1[SIW-1:0]] <= push1_lo;
            stk_hi_reg[sp_p1[SIW-1:0]] <= push1_hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            len_reg     <= LW'(ARRAY_DEPTH);
            clr_reg     <= '0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            clr_reg     <= clr_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        amt_reg    <= amt_next;
        total_reg  <= total_next;
        status_reg <= status_next;
        p_reg      <= p_next;
        bs_reg     <= bs_next;
        prod_reg   <= prod_next;
        n_reg      <= n_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

FILE: sv/rarst_checker.sv
// ----------------------------------------------------------------------------
// rarst_checker
// Port-level checks for the range-add / range-sum tree block.
// ----------------------------------------------------------------------------
module rarst_checker
    import rarst_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 psel,
    input logic                 penable,
    input logic                 pwrite,
    input logic [2:0]           paddr
);

    // One request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a request was in progress");

    // A rejected request carries a zero total.
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("rejected request with a nonzero total");

    // A length write starts a clearing pass that blocks input.
    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && !paddr[2] |=> !s_tready)
        else $error("input open right after a length write");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind range_add_range_sum_tree rarst_checker u_rarst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr)
);

FILE: bench/range_add_range_sum_tree_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_tb
// Self-checking bench for the lazy range-add / range-sum tree.
// ----------------------------------------------------------------------------
// Requests go in on the s_ stream with random gaps, and results are taken from
// the m_ stream with random stalls. A behavioral tree in the bench predicts
// every result when its request transfer happens. Results are then checked in
// order, field by field. The active length is rewritten between phases, which
// covers the clamped values, the smallest array and the unknown register
// address. Random requests are mostly valid ranges with a share of
// invalid ones.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_tb;
    import rarst_pkg::*;

    localparam int unsigned DEPTH = 1024;
    localparam int unsigned SLOTS = 2 * DEPTH;
    localparam logic [2:0] ADDR_LENGTH = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    typedef struct {
        logic [TOTAL_W-1:0] total;
        logic               status;
    } tree_result_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    logic [63:0] pend_mem [SLOTS];
    logic [63:0] below_mem [SLOTS];
    int unsigned model_length;

    tree_result_t expected_results[$];
    int unsigned error_count;
    int unsigned add_count;
    int unsigned query_count;
    int unsigned invalid_count;
    int unsigned checked_count;
    int unsigned length_writes;
    bit no_idle;

    range_add_range_sum_tree dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

    function automatic void clear_tree();
        for (int i = 0; i < SLOTS; i++) begin
            pend_mem[i] = '0;
            below_mem[i] = '0;
        end
    endfunction

    function automatic void tree_add(int unsigned n, int unsigned a, int unsigned b,
                                     int unsigned lo, int unsigned hi, logic [63:0] v);
        int unsigned m;
        int unsigned left;
        int unsigned right;
        if (n >= SLOTS || a > b) return;
        if (lo == a && hi == b) begin
            pend_mem[n] += v;
            return;
        end
        m = a + (b - a) / 2;
        below_mem[n] += v * 64'(hi - lo + 1);
        left = n + 1;
        right = n + 2 * (m - a + 1);
        if (lo > m) begin
            tree_add(right, m + 1, b, lo, hi, v);
        end else if (hi <= m) begin
            tree_add(left, a, m, lo, hi, v);
        end else begin
            tree_add(left, a, m, lo, m, v);
            tree_add(right, m + 1, b, m + 1, hi, v);
        end
    endfunction

    function automatic logic [63:0] tree_sum(int unsigned n, int unsigned a,
                                             int unsigned b, int unsigned lo,
                                             int unsigned hi);
        int unsigned m;
        int unsigned left;
        int unsigned right;
        logic [63:0] p;
        logic [63:0] span;
        if (n >= SLOTS || a > b) return '0;
        span = 64'(b - a + 1);
        if (lo == a && hi == b) return pend_mem[n] * span + below_mem[n];
        m = a + (b - a) / 2;
        left = n + 1;
        right = n + 2 * (m - a + 1);
        p = pend_mem[n];
        below_mem[n] += span * p;
        if (left < SLOTS) pend_mem[left] += p;
        if (right < SLOTS) pend_mem[right] += p;
        pend_mem[n] = '0;
        if (lo > m) return tree_sum(right, m + 1, b, lo, hi);
        if (hi <= m) return tree_sum(left, a, m, lo, hi);
        return tree_sum(left, a, m, lo, m) + tree_sum(right, m + 1, b, m + 1, hi);
    endfunction

    function automatic tree_result_t predict_request(logic kind, logic [9:0] lo,
                                                     logic [9:0] hi, logic [31:0] amt);
        tree_result_t r;
        r.total = '0;
        r.status = STATUS_DONE;
        if (lo > hi || hi >= model_length) begin
            r.status = STATUS_INVALID;
            invalid_count++;
        end else if (kind == REQ_ADD) begin
            tree_add(0, 0, model_length - 1, lo, hi, {{32{amt[31]}}, amt});
            add_count++;
        end else begin
            r.total = tree_sum(0, 0, model_length - 1, lo, hi);
            query_count++;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field, want, got);
        error_count++;
    endtask

    task automatic send_request(logic kind, logic [9:0] lo, logic [9:0] hi,
                                logic [31:0] amt);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{(S_TDATA_W - 52){1'b0}}, amt, hi, lo};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        expected_results.push_back(predict_request(kind, lo, hi, amt));
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        int unsigned v;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_LENGTH) begin
            v = value & 32'h7FF;
            if (v == 0) v = 1;
            if (v > DEPTH) v = DEPTH;
            model_length = v;
            clear_tree();
            length_writes++;
        end
    endtask

    task automatic send_random(int unsigned count);
        logic [9:0] lo;
        logic [9:0] hi;
        logic [31:0] amt;
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 85) begin
                lo = 10'($urandom_range(0, model_length - 1));
                if ($urandom_range(0, 2) == 0)
                    hi = 10'($urandom_range(lo, (lo + 3 < model_length) ? lo + 3
                                                                        : model_length - 1));
                else
                    hi = 10'($urandom_range(lo, model_length - 1));
            end else begin
                lo = 10'($urandom);
                hi = 10'($urandom);
            end
            case ($urandom_range(0, 9))
                0: amt = 32'h8000_0000;
                1: amt = 32'h7FFF_FFFF;
                2: amt = 32'($urandom_range(0, 15)) - 32'd8;
                default: amt = 32'($urandom);
            endcase
            send_request(1'($urandom_range(0, 1)), lo, hi, amt);
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_directed_full_length();
        send_request(REQ_ADD, 10'd0, 10'd1023, 32'h7FFF_FFFF);
        send_request(REQ_ADD, 10'd1023, 10'd1023, 32'h8000_0000);
        send_request(REQ_QUERY, 10'd0, 10'd1023, 32'h0);
        send_request(REQ_QUERY, 10'd0, 10'd0, 32'hFFFF_FFFF);
        send_request(REQ_QUERY, 10'd1023, 10'd1023, 32'h0);
        send_request(REQ_ADD, 10'd0, 10'd0, 32'hFFFF_FFFF);
        send_request(REQ_ADD, 10'd300, 10'd700, 32'h1234_5678);
        send_request(REQ_QUERY, 10'd511, 10'd512, 32'h0);
        send_request(REQ_QUERY, 10'd300, 10'd700, 32'h0);
        send_request(REQ_QUERY, 10'd5, 10'd4, 32'h0);
        send_request(REQ_ADD, 10'd1023, 10'd0, 32'h5555_5555);
        send_request(REQ_QUERY, 10'd0, 10'd1023, 32'h0);
        wait_idle();
    endtask

    task automatic test_length_clamps();
        write_register(ADDR_LENGTH, 32'd0);
        send_request(REQ_QUERY, 10'd0, 10'd0, 32'h0);
        send_request(REQ_ADD, 10'd0, 10'd0, 32'h8000_0000);
        send_request(REQ_QUERY, 10'd0, 10'd1, 32'h0);
        send_request(REQ_ADD, 10'd1, 10'd1, 32'h1);
        send_request(REQ_QUERY, 10'd0, 10'd0, 32'h0);
        wait_idle();
        write_register(ADDR_LENGTH, 32'd2047);
        send_request(REQ_QUERY, 10'd0, 10'd1023, 32'h0);
        send_request(REQ_ADD, 10'd2, 10'd9, 32'd77);
        wait_idle();
        write_register(ADDR_UNUSED, 32'd5);
        send_request(REQ_QUERY, 10'd0, 10'd1023, 32'h0);
        send_request(REQ_QUERY, 10'd9, 10'd9, 32'h0);
        wait_idle();
    endtask

    task automatic test_random_lengths();
        write_register(ADDR_LENGTH, 32'd1024);
        send_random(500);
        write_register(ADDR_LENGTH, 32'd1);
        send_random(100);
        write_register(ADDR_LENGTH, 32'd2);
        send_random(150);
        write_register(ADDR_LENGTH, 32'd7);
        send_random(250);
        write_register(ADDR_LENGTH, 32'd100);
        send_random(300);
        write_register(ADDR_LENGTH, 32'd1000);
        send_random(200);
        write_register(ADDR_LENGTH, 32'hFFFF_F800);
        send_random(30);
        write_register(ADDR_LENGTH, 32'd1024);
        send_random(150);
    endtask

    initial begin
        tree_result_t want;
        int unsigned stall;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", '0, m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.total) report_mismatch("range_total", want.total, m_tdata);
                if (m_tuser !== want.status) begin
                    report_mismatch("status", 64'(want.status), 64'(m_tuser));
                end
                checked_count++;
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= REQ_ADD;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        no_idle = 1'b0;
        model_length = DEPTH;
        clear_tree();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_full_length();
        test_length_clamps();
        test_random_lengths();

        repeat (50) @(posedge aclk);
        $display("Checked %0d results: %0d adds, %0d queries, %0d invalid ranges.",
                 checked_count, add_count, query_count, invalid_count);
        $display("Active length was rewritten %0d times, down to one element.",
                 length_writes);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
